@@ rtl/core/aarm_pkg.sv @@
// Shared types, constants and the arctangent table of the rotation matrix core.
`timescale 1ns / 1ps
`default_nettype none
package aarm_pkg;

  // Angle constants in Q16.16 degrees
  localparam logic signed [25:0] Deg360 = 26'sd23592960;
  localparam logic signed [25:0] Deg180 = 26'sd11796480;
  localparam logic signed [25:0] Deg90  = 26'sd5898240;

  // Reciprocal of 360 scaled by 2^26, rounded up
  localparam logic [17:0] Recip360 = 18'd186414;
  // Offset that makes the integer degree part non-negative (multiple of 360)
  localparam logic signed [17:0] DegOffset = 18'sd36000;

  // CORDIC gain in Q30 and table length
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;
  localparam int TableLen = 24;

  // One classified item handed from the front to the back
  typedef struct packed {
    logic [2:0][15:0]   mag;      // |axis component|
    logic [2:0]         neg;      // component sign
    logic               zero;     // all components zero
    logic [31:0]        ss;       // sum of squares
    logic signed [33:0] z;        // folded angle, Q24 degrees
    logic               neg_cos;  // cosine sign flip from folding
  } fe_t;

  // Arctangent of 2^-i in Q24 degrees
  function automatic logic signed [33:0] atan_q24(input int i);
    logic signed [33:0] r;
    begin
      case (i)
        0:  r = 34'sd754974720;
        1:  r = 34'sd445687602;
        2:  r = 34'sd235489088;
        3:  r = 34'sd119537938;
        4:  r = 34'sd60000934;
        5:  r = 34'sd30029717;
        6:  r = 34'sd15018523;
        7:  r = 34'sd7509720;
        8:  r = 34'sd3754917;
        9:  r = 34'sd1877466;
        10: r = 34'sd938734;
        11: r = 34'sd469367;
        12: r = 34'sd234684;
        13: r = 34'sd117342;
        14: r = 34'sd58671;
        15: r = 34'sd29335;
        16: r = 34'sd14668;
        17: r = 34'sd7334;
        18: r = 34'sd3667;
        19: r = 34'sd1833;
        20: r = 34'sd917;
        21: r = 34'sd458;
        22: r = 34'sd229;
        23: r = 34'sd115;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/aarm_front.sv @@
// Front end: takes input transfers, forms squares and reduces the angle.
`timescale 1ns / 1ps
`default_nettype none
module aarm_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] vx_i,
  input  wire logic signed [15:0] vy_i,
  input  wire logic signed [15:0] vz_i,
  input  wire logic signed [31:0] ang_i,
  output logic                    push_o,
  input  wire logic               full_i,
  output aarm_pkg::fe_t           entry_o
);

  logic a_valid_q, b_valid_q, ce;
  logic signed [15:0] a_v_q [3];
  logic signed [31:0] a_ang_q;

  logic [31:0]  b_sq_q [3];
  logic [15:0]  b_mag_q [3];
  logic [2:0]   b_neg_q;
  logic [17:0]  b_u_q;
  logic [8:0]   b_quo_q;
  logic [15:0]  b_frac_q;

  assign ce         = !b_valid_q || !full_i;
  assign in_ready_o = ce;
  assign push_o     = b_valid_q && !full_i;

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (ce) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (ce) begin
      a_v_q[0] <= vx_i;
      a_v_q[1] <= vy_i;
      a_v_q[2] <= vz_i;
      a_ang_q  <= ang_i;
    end
  end

  // Squares, magnitudes and quotient estimate of degrees / 360
  logic signed [17:0] u_d;
  logic [34:0]        prod_d;
  assign u_d    = 18'(signed'(a_ang_q[31:16])) + aarm_pkg::DegOffset;
  assign prod_d = 35'(u_d[16:0]) * 35'(aarm_pkg::Recip360);

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        b_sq_q[i]  <= 32'(a_v_q[i] * a_v_q[i]);
        b_mag_q[i] <= a_v_q[i][15] ? 16'(-a_v_q[i]) : a_v_q[i];
        b_neg_q[i] <= a_v_q[i][15];
      end
      b_u_q    <= u_d;
      b_quo_q  <= prod_d[34:26];
      b_frac_q <= a_ang_q[15:0];
    end
  end

  // Remainder correction and folding into [-90, 90] degrees
  logic signed [18:0] rem0, rem1;
  logic [8:0]         rem;
  logic signed [25:0] r0, r1, rf;
  logic               nc;
  logic [31:0]        ss;

  always_comb begin
    rem0 = 19'(signed'({1'b0, b_u_q})) - 19'(signed'({1'b0, b_quo_q})) * 19'sd360;
    rem1 = rem0;
    if (rem0 < 0) rem1 = rem0 + 19'sd360;
    else if (rem0 >= 19'sd360) rem1 = rem0 - 19'sd360;
    rem = rem1[8:0];
    r0  = signed'({1'b0, rem, b_frac_q});
    r1  = (r0 >= aarm_pkg::Deg180) ? r0 - aarm_pkg::Deg360 : r0;
    rf  = r1;
    nc  = 1'b0;
    if (r1 > aarm_pkg::Deg90) begin
      rf = aarm_pkg::Deg180 - r1;
      nc = 1'b1;
    end else if (r1 < -aarm_pkg::Deg90) begin
      rf = -aarm_pkg::Deg180 - r1;
      nc = 1'b1;
    end
    ss = b_sq_q[0] + b_sq_q[1] + b_sq_q[2];
    entry_o.mag[0]  = b_mag_q[0];
    entry_o.mag[1]  = b_mag_q[1];
    entry_o.mag[2]  = b_mag_q[2];
    entry_o.neg     = b_neg_q;
    entry_o.zero    = (ss == 32'd0);
    entry_o.ss      = ss;
    entry_o.z       = 34'(rf) <<< 8;
    entry_o.neg_cos = nc;
  end

endmodule
`default_nettype wire

@@ rtl/core/aarm_fifo.sv @@
// Short queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module aarm_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire aarm_pkg::fe_t  wdata_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output aarm_pkg::fe_t       rdata_o
);

  aarm_pkg::fe_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q[2];
  assign empty_o = (cnt_q == 3'd0);
  assign rdata_o = mem_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

endmodule
`default_nettype wire

@@ rtl/core/aarm_back.sv @@
// Back end: square root, divides, CORDIC and matrix assembly in one pipeline.
`timescale 1ns / 1ps
`default_nettype none
module aarm_back #(
  parameter int CORDIC_STEPS  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire aarm_pkg::fe_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [8:0][15:0]    mat_o,
  output logic                zero_o
);

  localparam int NC   = (CORDIC_STEPS < aarm_pkg::TableLen) ? CORDIC_STEPS
                                                             : aarm_pkg::TableLen;
  localparam int NST  = 63;  // 32 root steps then 31 quotient steps
  localparam int SH   = 30 - OUT_FRAC_BITS;
  localparam logic signed [35:0] Rnd = (SH > 0) ? (36'sd1 <<< (SH - 1)) : 36'sd0;
  localparam logic signed [35:0] Lim = 36'sd1 <<< OUT_FRAC_BITS;

  typedef struct packed {
    aarm_pkg::fe_t            f;
    logic [35:0]              rrem;
    logic [31:0]              root;
    logic [2:0][32:0]         drem;
    logic [2:0][30:0]         quo;
    logic signed [33:0]       cx;
    logic signed [33:0]       cy;
  } st_t;

  // One pipeline step; k selects root, quotient and CORDIC work
  function automatic st_t step(input st_t s, input int k);
    st_t o;
    logic [35:0] r2, tr;
    logic [1:0]  pr;
    logic [32:0] d2;
    logic signed [33:0] dx, dy;
    int j;
    begin
      o  = s;
      j  = 32 - k;
      pr = 2'b00;
      if (k <= 32) begin
        if (j >= 16) pr = s.f.ss[2*(j-16) +: 2];
        r2 = {s.rrem[33:0], pr};
        tr = {2'b00, s.root, 2'b01};
        if (r2 >= tr) begin
          o.rrem = r2 - tr;
          o.root = {s.root[30:0], 1'b1};
        end else begin
          o.rrem = r2;
          o.root = {s.root[30:0], 1'b0};
        end
      end else begin
        for (int c = 0; c < 3; c++) begin
          d2 = {s.drem[c][31:0], 1'b0};
          if (d2 >= {1'b0, s.root}) begin
            o.drem[c] = d2 - {1'b0, s.root};
            o.quo[c]  = {s.quo[c][29:0], 1'b1};
          end else begin
            o.drem[c] = d2;
            o.quo[c]  = {s.quo[c][29:0], 1'b0};
          end
        end
      end
      if (k <= NC) begin
        dx = s.cy >>> (k - 1);
        dy = s.cx >>> (k - 1);
        if (s.f.z >= 0) begin
          o.cx  = s.cx - dx;
          o.cy  = s.cy + dy;
          o.f.z = s.f.z - aarm_pkg::atan_q24(k - 1);
        end else begin
          o.cx  = s.cx + dx;
          o.cy  = s.cy - dy;
          o.f.z = s.f.z + aarm_pkg::atan_q24(k - 1);
        end
      end
      return o;
    end
  endfunction

  logic ce;
  logic [NST:1] vld_q;
  st_t st_q [NST+1];
  logic m1_valid_q, m2_valid_q, m3_valid_q;

  assign ce    = !out_valid_o || out_ready_i;
  assign pop_o = ce && !empty_i;

  // Stage zero seeds the lanes from the queue head
  always_comb begin
    st_q[0].f    = head_i;
    st_q[0].rrem = '0;
    st_q[0].root = '0;
    for (int c = 0; c < 3; c++) begin
      st_q[0].drem[c] = {2'b00, head_i.mag[c], 15'd0};
      st_q[0].quo[c]  = '0;
    end
    st_q[0].cx = aarm_pkg::GainQ30;
    st_q[0].cy = '0;
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      m1_valid_q  <= 1'b0;
      m2_valid_q  <= 1'b0;
      m3_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (ce) begin
      vld_q       <= {vld_q[NST-1:1], !empty_i};
      m1_valid_q  <= vld_q[NST];
      m2_valid_q  <= m1_valid_q;
      m3_valid_q  <= m2_valid_q;
      out_valid_o <= m3_valid_q;
    end
  end

  // Root, quotient and CORDIC steps
  for (genvar k = 1; k <= NST; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (ce) st_q[k] <= step(st_q[k-1], k);
    end
  end

  // Signed unit axis and sin / cos
  logic signed [31:0] n_q [3];
  logic signed [33:0] s1_q, c1_q;
  logic               z1_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) begin
        if (st_q[NST].f.zero)        n_q[c] <= '0;
        else if (st_q[NST].f.neg[c]) n_q[c] <= -signed'({1'b0, st_q[NST].quo[c]});
        else                         n_q[c] <= signed'({1'b0, st_q[NST].quo[c]});
      end
      s1_q <= st_q[NST].cy;
      c1_q <= st_q[NST].f.neg_cos ? -st_q[NST].cx : st_q[NST].cx;
      z1_q <= st_q[NST].f.zero;
    end
  end

  // Outer products of the axis and sin-weighted axis
  logic signed [63:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [65:0] psx, psy, psz;
  logic signed [31:0] oo_q [6];
  logic signed [33:0] sn_q [3];
  logic signed [34:0] t_q;
  logic signed [33:0] c2_q;
  logic               z2_q;
  assign pxx = n_q[0] * n_q[0];
  assign pyy = n_q[1] * n_q[1];
  assign pzz = n_q[2] * n_q[2];
  assign pxy = n_q[0] * n_q[1];
  assign pxz = n_q[0] * n_q[2];
  assign pyz = n_q[1] * n_q[2];
  assign psx = 66'(s1_q) * 66'(n_q[0]);
  assign psy = 66'(s1_q) * 66'(n_q[1]);
  assign psz = 66'(s1_q) * 66'(n_q[2]);
  always_ff @(posedge clk_i) begin
    if (ce) begin
      oo_q[0] <= pxx[61:30];
      oo_q[1] <= pyy[61:30];
      oo_q[2] <= pzz[61:30];
      oo_q[3] <= pxy[61:30];
      oo_q[4] <= pxz[61:30];
      oo_q[5] <= pyz[61:30];
      sn_q[0] <= psx[63:30];
      sn_q[1] <= psy[63:30];
      sn_q[2] <= psz[63:30];
      t_q     <= 35'sd1073741824 - 35'(c1_q);
      c2_q    <= c1_q;
      z2_q    <= z1_q;
    end
  end

  // Scale by one minus cosine
  logic signed [34:0] w_q [6];
  logic signed [33:0] sn3_q [3];
  logic signed [33:0] c3_q;
  logic               z3_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 6; i++) begin
        w_q[i] <= 35'((67'(oo_q[i]) * 67'(t_q)) >>> 30);
      end
      sn3_q <= sn_q;
      c3_q  <= c2_q;
      z3_q  <= z2_q;
    end
  end

  // Round to the output format and clamp to plus or minus one
  function automatic logic [15:0] to_out(input logic signed [35:0] v);
    logic signed [35:0] r;
    begin
      r = (v + Rnd) >>> SH;
      if (r > Lim) r = Lim;
      if (r < -Lim) r = -Lim;
      return r[15:0];
    end
  endfunction

  logic signed [35:0] e [9];
  always_comb begin
    e[0] = 36'(c3_q) + 36'(w_q[0]);
    e[1] = 36'(w_q[3]) - 36'(sn3_q[2]);
    e[2] = 36'(w_q[4]) + 36'(sn3_q[1]);
    e[3] = 36'(w_q[3]) + 36'(sn3_q[2]);
    e[4] = 36'(c3_q) + 36'(w_q[1]);
    e[5] = 36'(w_q[5]) - 36'(sn3_q[0]);
    e[6] = 36'(w_q[4]) - 36'(sn3_q[1]);
    e[7] = 36'(w_q[5]) + 36'(sn3_q[0]);
    e[8] = 36'(c3_q) + 36'(w_q[2]);
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 9; i++) mat_o[i] <= to_out(e[i]);
      zero_o <= z3_q;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/axis_angle_rotation_matrix_core.sv @@
// Top level: axis-angle to rotation matrix, streaming ports.
// Path from input to result: 2 front stages, the queue, 32 square-root steps,
// 31 divide steps (one step per stage), 3 matrix stages, output register.
// Throughput: one item per cycle while the output is not stalled.
// Reset clears all valid flags and the queue; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module axis_angle_rotation_matrix_core #(
  parameter int CORDIC_STEPS  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [79:0]  s_axis_tdata,   // axis_x, axis_y, axis_z, angle_deg
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic              m_axis_tuser    // zero_axis
);

  logic           push, full, pop, empty;
  aarm_pkg::fe_t  wentry, head;
  logic [8:0][15:0] mat;

  aarm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .vx_i       (s_axis_tdata[15:0]),
    .vy_i       (s_axis_tdata[31:16]),
    .vz_i       (s_axis_tdata[47:32]),
    .ang_i      (s_axis_tdata[79:48]),
    .push_o     (push),
    .full_i     (full),
    .entry_o    (wentry)
  );

  aarm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head)
  );

  aarm_back #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .mat_o       (mat),
    .zero_o      (m_axis_tuser)
  );

  assign m_axis_tdata = mat;

endmodule
`default_nettype wire

@@ test/rotation_matrix_checker.sv @@
// Checker for the rotation matrix core: predicts each matrix and compares results.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_checker #(
  parameter int CORDIC_STEPS  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic         clk_i,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [79:0]  s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [143:0] m_axis_tdata,
  input  wire logic         m_axis_tuser,
  output int                fail_count,
  output int                pending_count
);

  typedef struct {
    logic [143:0] mat;
    logic         zero_axis;
  } matrix_t;

  matrix_t matrix_q[$];

  // Floor shift of a signed value
  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(input longint unsigned num);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > num) bit_v >>= 2;
    while (bit_v != 0) begin
      if (num >= res + bit_v) begin
        num -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint unit_component(input longint v, input longint len);
    longint unsigned mag, q;
    mag = (v < 0) ? -v : v;
    q = (mag << 46) / len;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] quantise(input longint v);
    int sh;
    longint lim;
    sh = 30 - OUT_FRAC_BITS;
    lim = 64'sd1 << OUT_FRAC_BITS;
    if (sh > 0) v = floor_shr(v + (64'sd1 << (sh - 1)), sh);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  function automatic matrix_t predict_matrix(input logic [79:0] d);
    matrix_t r;
    longint vx, vy, vz, ang, nx, ny, nz, len, rr, x, y, z, dx, dy, s, c, t;
    longint xx, yy, zz, xy, xz, yz, sx, sy, sz;
    longint unsigned ss;
    logic neg_cos;
    int steps;
    vx = longint'($signed(d[15:0]));
    vy = longint'($signed(d[31:16]));
    vz = longint'($signed(d[47:32]));
    ang = longint'($signed(d[79:48]));
    ss = vx * vx + vy * vy + vz * vz;
    nx = 0; ny = 0; nz = 0;
    if (ss != 0) begin
      len = int_sqrt(ss << 32);
      nx = unit_component(vx, len);
      ny = unit_component(vy, len);
      nz = unit_component(vz, len);
    end
    // Angle reduction and folding into [-90, 90]
    rr = ang % longint'(aarm_pkg::Deg360);
    neg_cos = 1'b0;
    if (rr < 0) rr += aarm_pkg::Deg360;
    if (rr >= aarm_pkg::Deg180) rr -= aarm_pkg::Deg360;
    if (rr > aarm_pkg::Deg90) begin
      rr = aarm_pkg::Deg180 - rr;
      neg_cos = 1'b1;
    end else if (rr < -longint'(aarm_pkg::Deg90)) begin
      rr = -longint'(aarm_pkg::Deg180) - rr;
      neg_cos = 1'b1;
    end
    // CORDIC rotation in degrees
    x = aarm_pkg::GainQ30;
    y = 0;
    z = rr * 256;
    steps = (CORDIC_STEPS < aarm_pkg::TableLen) ? CORDIC_STEPS : aarm_pkg::TableLen;
    for (int i = 0; i < steps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= aarm_pkg::atan_q24(i);
      end else begin
        x += dx; y -= dy; z += aarm_pkg::atan_q24(i);
      end
    end
    s = y;
    c = neg_cos ? -x : x;
    t = (64'sd1 <<< 30) - c;
    xx = floor_shr(floor_shr(nx * nx, 30) * t, 30);
    yy = floor_shr(floor_shr(ny * ny, 30) * t, 30);
    zz = floor_shr(floor_shr(nz * nz, 30) * t, 30);
    xy = floor_shr(floor_shr(nx * ny, 30) * t, 30);
    xz = floor_shr(floor_shr(nx * nz, 30) * t, 30);
    yz = floor_shr(floor_shr(ny * nz, 30) * t, 30);
    sx = floor_shr(s * nx, 30);
    sy = floor_shr(s * ny, 30);
    sz = floor_shr(s * nz, 30);
    r.mat = {quantise(c + zz), quantise(yz + sx), quantise(xz - sy),
             quantise(yz - sx), quantise(c + yy), quantise(xy + sz),
             quantise(xz + sy), quantise(xy - sz), quantise(c + xx)};
    r.zero_axis = (ss == 0);
    return r;
  endfunction

  initial fail_count = 0;
  assign pending_count = matrix_q.size();

  // Predict on input transfers, compare on output transfers
  always @(posedge clk_i) begin
    matrix_t want;
    if (s_axis_tvalid && s_axis_tready) matrix_q.push_back(predict_matrix(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected result %h user %b", $time, m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = matrix_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (want.mat[k*16 +: 16] !== m_axis_tdata[k*16 +: 16]) begin
            $display("%0t: m%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                     want.mat[k*16 +: 16], m_axis_tdata[k*16 +: 16]);
            fail_count++;
          end
        if (want.zero_axis !== m_axis_tuser) begin
          $display("%0t: zero_axis expected %b actual %b", $time, want.zero_axis,
                   m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ test/tb_axis_angle_rotation_matrix_core.sv @@
// Testbench top: stimulus, idling and verdict for the rotation matrix core.
`timescale 1ns / 1ps
`default_nettype none
module tb_axis_angle_rotation_matrix_core;

  localparam int RandomItems = 1350;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 120;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;
  int           fail_count, pending_count;
  int           send_idle_pct = 27, recv_idle_pct = 81;
  longint       cycle_count = 0;

  axis_angle_rotation_matrix_core dut (.*);

  rotation_matrix_checker checker_i (.*);

  initial forever #2 clk_i = ~clk_i;

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stalls
  always @(posedge clk_i)
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);

  // Hold one item valid until transferred, with random gaps first
  task automatic send_item(input logic [79:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_component();
    case ($urandom_range(4))
      0: return 16'(0);
      1: return 16'($urandom_range(15)) - 16'd7;
      2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(3))
      0: return 32'(($urandom_range(8) * 45 - 180)) << 16;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [15:0] ax, ay, az;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: zero axis, extreme components and angles, folding edges
    send_item({32'd0, 48'd0});
    send_item({32'sd90 <<< 16, 48'd0});
    send_item({32'h8000_0000, 16'h8000, 16'h8000, 16'h8000});
    send_item({32'h7fff_ffff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_item({32'h0000_0001, 16'h0001, 16'h0000, 16'h0000});
    send_item({32'hffff_ffff, 16'h0000, 16'hffff, 16'h0000});
    send_item({32'sd180 <<< 16, 16'h0100, 16'h0000, 16'h0000});
    send_item({-(32'sd180 <<< 16), 16'h0000, 16'h0000, 16'h0100});
    send_item({32'sd360 <<< 16, 16'h0100, 16'h0100, 16'h0100});
    send_item({-(32'sd90 <<< 16), 16'h0000, 16'h0100, 16'h0000});
    send_item({(32'sd90 <<< 16) + 1, 16'hff00, 16'h0100, 16'h0000});
    send_item({-(32'sd90 <<< 16) - 1, 16'h0100, 16'hff00, 16'h7fff});
    send_item({32'sd270 <<< 16, 16'h8000, 16'h0000, 16'h0001});
    send_item({32'sd45 <<< 16, 16'h0001, 16'h0001, 16'h0001});
    // Random, three idling phases
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 27 : (p == 1) ? 81 : 0;
      recv_idle_pct = (p == 0) ? 81 : (p == 1) ? 27 : 0;
      for (int n = 0; n < RandomItems / 3; n++) begin
        ax = rand_component();
        ay = rand_component();
        az = rand_component();
        send_item({rand_angle(), az, ay, ax});
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/aarm_pkg.sv
rtl/core/aarm_front.sv
rtl/core/aarm_fifo.sv
rtl/core/aarm_back.sv
rtl/core/axis_angle_rotation_matrix_core.sv
test/rotation_matrix_checker.sv
test/tb_axis_angle_rotation_matrix_core.sv
